### rtl/bhc_pkg.sv
package bhc_pkg;

   // Sizing
   localparam int MAX_BUCKETS    = 7;
   localparam int COUNT_BITS     = 32;
   localparam int NUM_BOUND_REGS = 7;
   localparam int BKT_SLOTS      = (MAX_BUCKETS < NUM_BOUND_REGS) ? MAX_BUCKETS : NUM_BOUND_REGS;
   localparam int BKT_W          = (BKT_SLOTS > 1) ? $clog2(BKT_SLOTS) : 1;
   localparam int BND_W          = (NUM_BOUND_REGS > 1) ? $clog2(NUM_BOUND_REGS) : 1;

   // Field widths
   localparam int SAMPLE_W    = 32;
   localparam int SUM_W       = 64;
   localparam int OUT_COUNT_W = 32;
   localparam int OUT_NUM_W   = 3;
   localparam int USE_W       = 3;
   localparam int CSR_IDX_W   = 4;
   localparam int CSR_DATA_W  = 32;

   typedef logic [COUNT_BITS-1:0]                   count_type;
   typedef logic [SAMPLE_W-1:0]                     sample_type;
   typedef logic [SUM_W-1:0]                        sum_type;
   typedef logic [BKT_W-1:0]                        bkt_idx_type;
   typedef logic [USE_W-1:0]                        use_type;
   typedef logic [NUM_BOUND_REGS-1:0][SAMPLE_W-1:0] bound_arr_type;

   // Request opcodes
   typedef enum logic {
      OP_OBSERVE = 1'b0,
      OP_COLLECT = 1'b1
   } op_type;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_BOUNDARY_0     = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_BUCKETS_IN_USE = CSR_IDX_W'(NUM_BOUND_REGS);
   localparam use_type              USE_RESET          = USE_W'(7);

   // Collect sequencer
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_CALC,
      ST_SEND
   } state_type;

   // Count bank control
   typedef struct packed {
      bkt_idx_type rd_addr;
      logic        wr_en;
      bkt_idx_type wr_addr;
   } bank_ctrl_type;

   localparam count_type COUNT_MAX = '1;

   function automatic count_type sat_inc(input count_type c);
      return (c == COUNT_MAX) ? c : c + count_type'(1);
   endfunction

   function automatic count_type sat_add(input count_type a, input count_type b);
      logic [COUNT_BITS:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[COUNT_BITS] ? COUNT_MAX : s[COUNT_BITS-1:0];
   endfunction

   function automatic logic [OUT_COUNT_W-1:0] clamp_out(input count_type c);
      logic [127:0] w;
      w = 128'(c);
      return (w > 128'(64'hFFFF_FFFF)) ? '1 : w[OUT_COUNT_W-1:0];
   endfunction

endpackage

### rtl/bhc_req_if.sv
interface bhc_req_if;
   import bhc_pkg::*;

   logic       valid;
   logic       ready;
   op_type     op;
   sample_type sample;

   modport source (output valid, output op, output sample, input ready);
   modport sink   (input valid, input op, input sample, output ready);
endinterface

### rtl/bhc_rsp_if.sv
interface bhc_rsp_if;
   import bhc_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [OUT_NUM_W-1:0]   bucket_number;
   sample_type             bucket_bound;
   logic [OUT_COUNT_W-1:0] cum_count;
   sum_type                sum_value;
   logic                   is_last;

   modport source (output valid, output bucket_number, output bucket_bound,
                   output cum_count, output sum_value, output is_last,
                   input ready);
   modport sink   (input valid, input bucket_number, input bucket_bound,
                   input cum_count, input sum_value, input is_last,
                   output ready);
endinterface

### rtl/bhc_csr_if.sv
interface bhc_csr_if;
   import bhc_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/bhc_classify.sv
module bhc_classify (
   input  bhc_pkg::bound_arr_type bounds,
   input  bhc_pkg::use_type       n_active,
   input  bhc_pkg::sample_type    sample,
   output logic                   hit,
   output bhc_pkg::bkt_idx_type   idx
);
   import bhc_pkg::*;

   // Parallel signed compares, lowest matching bucket wins
   always_comb begin
      hit = 1'b0;
      idx = '0;
      for (int i = BKT_SLOTS - 1; i >= 0; i--) begin
         if ((i < int'(n_active)) && ($signed(bounds[i]) >= $signed(sample))) begin
            hit = 1'b1;
            idx = BKT_W'(i);
         end
      end
   end
endmodule

### rtl/bhc_count_bank.sv
module bhc_count_bank (
   input  logic                   clock,
   input  logic                   reset,
   input  bhc_pkg::bank_ctrl_type ctrl,
   input  bhc_pkg::count_type     wr_data,
   output bhc_pkg::count_type     rd_data
);
   import bhc_pkg::*;

   count_type                mem [BKT_SLOTS];
   logic [BKT_SLOTS-1:0]     vld_ff;
   logic [BKT_SLOTS-1:0]     vld_in;
   count_type                rd_q_ff;
   logic                     rd_vld_ff;

   // Per-entry valid bits stand in for a zero fill after reset
   always_comb begin
      vld_in = vld_ff;
      if (ctrl.wr_en) begin
         vld_in[ctrl.wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         vld_ff    <= vld_in;
         rd_vld_ff <= vld_ff[ctrl.rd_addr];
      end
   end

   // Single write port, registered read (old data on same-address collision)
   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         mem[ctrl.wr_addr] <= wr_data;
      end
      rd_q_ff <= mem[ctrl.rd_addr];
   end

   assign rd_data = rd_vld_ff ? rd_q_ff : '0;
endmodule

### rtl/bucket_histogram_counter.sv
// Cumulative bucket histogram. Observe beats bin a signed Q16.16 sample into
// the first active bucket whose upper boundary is at least the sample, bump
// that bucket's saturating count and add the sample into a wrapping 64-bit
// sum; samples above every active boundary are dropped. Observe beats are
// taken one per cycle while idle: counts live in a one-port-read, one-port-
// write memory with a registered read; the read-modify-write splits into
// classify-and-read and increment-and-write stages, with forwarding between
// back-to-back hits on one bucket. A collect beat returns one result beat per
// active bucket (bucket number, boundary, saturating cumulative count, running
// sum, last flag). Each result passes the memory read, accumulate and present
// states, held in present while the sink holds ready low; no request is taken
// until the final result is delivered. With zero buckets in use a collect
// returns nothing. Counts come up zero after reset without a clearing pass.
module bucket_histogram_counter (
   input logic  clock,
   input logic  reset,
   bhc_req_if.sink   req_bus,
   bhc_rsp_if.source rsp_bus,
   bhc_csr_if.sink   csr_bus
);
   import bhc_pkg::*;

   // Configuration registers
   bound_arr_type boundary_ff;
   bound_arr_type boundary_in;
   use_type       use_ff;
   use_type       use_in;
   use_type       n_active;

   // Sequencer and collect datapath
   state_type     state_ff;
   state_type     state_in;
   bkt_idx_type   k_ff;
   bkt_idx_type   k_in;
   count_type     cum_ff;
   count_type     cum_in;
   count_type     cum_next;
   logic          k_last;

   // Observe pipeline
   logic          cls_hit;
   bkt_idx_type   cls_idx;
   logic          s1_valid_ff;
   logic          s1_valid_in;
   bkt_idx_type   s1_idx_ff;
   sample_type    s1_sample_ff;
   logic          fwd_valid_ff;
   bkt_idx_type   fwd_idx_ff;
   count_type     fwd_data_ff;
   count_type     old_count;
   count_type     new_count;
   sum_type       sum_ff;
   sum_type       sum_in;

   // Count bank
   bank_ctrl_type bank_ctrl;
   count_type     rd_data;

   // Output register
   logic [OUT_NUM_W-1:0]   out_num_ff;
   logic [OUT_NUM_W-1:0]   out_num_in;
   sample_type             out_bound_ff;
   sample_type             out_bound_in;
   logic [OUT_COUNT_W-1:0] out_count_ff;
   logic [OUT_COUNT_W-1:0] out_count_in;
   logic                   out_last_ff;
   logic                   out_last_in;

   logic req_fire;
   logic rsp_fire;

   assign req_fire = req_bus.valid && req_bus.ready;
   assign rsp_fire = rsp_bus.valid && rsp_bus.ready;

   // CSR writes; unknown indexes fall through
   assign csr_bus.ready = 1'b1;

   always_comb begin
      boundary_in = boundary_ff;
      use_in      = use_ff;
      if (csr_bus.valid) begin
         if (csr_bus.index < REG_BUCKETS_IN_USE) begin
            boundary_in[BND_W'(csr_bus.index - REG_BOUNDARY_0)] = csr_bus.data[SAMPLE_W-1:0];
         end else if (csr_bus.index == REG_BUCKETS_IN_USE) begin
            use_in = csr_bus.data[USE_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         boundary_ff <= '0;
         use_ff      <= USE_RESET;
      end else begin
         boundary_ff <= boundary_in;
         use_ff      <= use_in;
      end
   end

   assign n_active = (int'(use_ff) > BKT_SLOTS) ? USE_W'(BKT_SLOTS) : use_ff;

   // Stage 0: bucket select from the request payload
   bhc_classify u_classify (
      .bounds   (boundary_ff),
      .n_active (n_active),
      .sample   (req_bus.sample),
      .hit      (cls_hit),
      .idx      (cls_idx)
   );

   assign s1_valid_in = req_fire && (req_bus.op == OP_OBSERVE) && cls_hit;

   // Stage 1: increment with forwarding from the previous write
   assign old_count = (fwd_valid_ff && (fwd_idx_ff == s1_idx_ff)) ? fwd_data_ff : rd_data;
   assign new_count = sat_inc(old_count);
   assign sum_in    = s1_valid_ff ?
                      sum_ff + {{(SUM_W-SAMPLE_W){s1_sample_ff[SAMPLE_W-1]}}, s1_sample_ff} :
                      sum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
         sum_ff       <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         fwd_valid_ff <= s1_valid_ff;
         sum_ff       <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_idx_ff    <= cls_idx;
      s1_sample_ff <= req_bus.sample;
      fwd_idx_ff   <= s1_idx_ff;
      fwd_data_ff  <= new_count;
   end

   assign bank_ctrl.rd_addr = (state_ff == ST_IDLE) ? cls_idx : k_ff;
   assign bank_ctrl.wr_en   = s1_valid_ff;
   assign bank_ctrl.wr_addr = s1_idx_ff;

   bhc_count_bank u_count_bank (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (bank_ctrl),
      .wr_data (new_count),
      .rd_data (rd_data)
   );

   // Collect sequencer: next state
   assign k_last = (int'(k_ff) + 1) == int'(n_active);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_bus.op == OP_COLLECT) && (n_active != '0)) begin
               state_in = ST_READ;
            end
         end
         ST_READ: state_in = ST_CALC;
         ST_CALC: state_in = ST_SEND;
         ST_SEND: begin
            if (rsp_bus.ready) begin
               state_in = k_last ? ST_IDLE : ST_READ;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Collect sequencer: outputs and datapath loads
   assign cum_next = sat_add(cum_ff, rd_data);

   always_comb begin
      req_bus.ready = 1'b0;
      rsp_bus.valid = 1'b0;
      k_in          = k_ff;
      cum_in        = cum_ff;
      out_num_in    = out_num_ff;
      out_bound_in  = out_bound_ff;
      out_count_in  = out_count_ff;
      out_last_in   = out_last_ff;
      case (state_ff)
         ST_IDLE: begin
            req_bus.ready = 1'b1;
            k_in          = '0;
            cum_in        = '0;
         end
         ST_READ: begin
         end
         ST_CALC: begin
            cum_in       = cum_next;
            out_num_in   = OUT_NUM_W'(k_ff);
            out_bound_in = boundary_ff[BND_W'(k_ff)];
            out_count_in = clamp_out(cum_next);
            out_last_in  = k_last;
         end
         ST_SEND: begin
            rsp_bus.valid = 1'b1;
            if (rsp_bus.ready) begin
               k_in = k_ff + BKT_W'(1);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff         <= k_in;
      cum_ff       <= cum_in;
      out_num_ff   <= out_num_in;
      out_bound_ff <= out_bound_in;
      out_count_ff <= out_count_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_bus.bucket_number = out_num_ff;
   assign rsp_bus.bucket_bound  = out_bound_ff;
   assign rsp_bus.cum_count     = out_count_ff;
   assign rsp_bus.sum_value     = sum_ff;
   assign rsp_bus.is_last       = out_last_ff;

   // No count update may be in flight while a collect walks the bank
   a_no_update_in_collect : assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !s1_valid_ff)
      else $error("count write during collect");

   // The final result returns the block to idle
   a_last_ends_collect : assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && rsp_bus.is_last) |=> (state_ff == ST_IDLE))
      else $error("collect did not end after last result");

   // Results only describe active buckets
   a_bucket_in_range : assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> (int'(rsp_bus.bucket_number) < int'(n_active)))
      else $error("result for inactive bucket");

   // A held result keeps its cumulative count
   a_count_held : assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && !rsp_bus.ready) |=> $stable(out_count_ff))
      else $error("result count changed while stalled");
endmodule

### bench/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bhc_pkg::*;

   localparam int CYCLE_LIMIT  = 400_000;
   localparam int SETTLE       = 8;      // drain time for the observe read-modify-write
   localparam int STALL_HOLD   = 300;    // long receiver hold-off, in cycles
   localparam int SEGMENTS     = 6;
   localparam int SEG_ITEMS    = 75;

   localparam logic [CSR_IDX_W-1:0] REG_SPARE_LO = REG_BUCKETS_IN_USE + CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_HI = '1;

   typedef enum logic {ROW_WRITE, ROW_BEAT} row_kind_type;

   // one directed step: either a register write or a request beat;
   // pinned collect rows also carry the typed-in total and sum
   typedef struct packed {
      row_kind_type          kind;
      op_type                op;
      logic [CSR_IDX_W-1:0]  index;
      logic [CSR_DATA_W-1:0] value;
      logic                  pinned;
      logic [OUT_COUNT_W-1:0] pin_total;
      sum_type               pin_sum;
   } script_row_type;

   typedef struct {
      logic [OUT_NUM_W-1:0]   bucket_number;
      sample_type             bucket_bound;
      logic [OUT_COUNT_W-1:0] cum_count;
      sum_type                sum_value;
      logic                   is_last;
   } bucket_report_type;

   localparam int SCRIPT_LEN = 36;

   script_row_type script [SCRIPT_LEN] = '{
      // right after reset: seven empty buckets at boundary zero
      '{ROW_BEAT,  OP_COLLECT, REG_BOUNDARY_0, 32'h0, 1'b1, 32'd0, 64'h0},
      // ascending boundaries from the most negative to the most positive value
      '{ROW_WRITE, OP_OBSERVE, REG_BOUNDARY_0,              32'h8000_0000, 1'b0, 32'd0, 64'h0},
      '{ROW_WRITE, OP_OBSERVE, REG_BOUNDARY_0 + 4'd1,       32'hFFFF_0000, 1'b0, 32'd0, 64'h0},
      '{ROW_WRITE, OP_OBSERVE, REG_BOUNDARY_0 + 4'd2,       32'h0000_0000, 1'b0, 32'd0, 64'h0},
      '{ROW_WRITE, OP_OBSERVE, REG_BOUNDARY_0 + 4'd3,       32'h0001_0000, 1'b0, 32'd0, 64'h0},
      '{ROW_WRITE, OP_OBSERVE, REG_BOUNDARY_0 + 4'd4,       32'h0064_0000, 1'b0, 32'd0, 64'h0},
      '{ROW_WRITE, OP_OBSERVE, REG_BOUNDARY_0 + 4'd5,       32'h7FFF_FFFE, 1'b0, 32'd0, 64'h0},
      '{ROW_WRITE, OP_OBSERVE, REG_BOUNDARY_0 + 4'd6,       32'h7FFF_FFFF, 1'b0, 32'd0, 64'h0},
      '{ROW_WRITE, OP_OBSERVE, REG_BUCKETS_IN_USE,          32'h0000_0007, 1'b0, 32'd0, 64'h0},
      // sample extremes and exact boundary hits
      '{ROW_BEAT,  OP_OBSERVE, REG_BOUNDARY_0, 32'h8000_0000, 1'b0, 32'd0, 64'h0},
      '{ROW_BEAT,  OP_OBSERVE, REG_BOUNDARY_0, 32'h7FFF_FFFF, 1'b0, 32'd0, 64'h0},
      '{ROW_BEAT,  OP_OBSERVE, REG_BOUNDARY_0, 32'h0000_0000, 1'b0, 32'd0, 64'h0},
      '{ROW_BEAT,  OP_OBSERVE, REG_BOUNDARY_0, 32'hFFFF_0000, 1'b0, 32'd0, 64'h0},
      '{ROW_BEAT,  OP_OBSERVE, REG_BOUNDARY_0, 32'h0001_0000, 1'b0, 32'd0, 64'h0},
      '{ROW_BEAT,  OP_OBSERVE, REG_BOUNDARY_0, 32'h0000_0001, 1'b0, 32'd0, 64'h0},
      '{ROW_BEAT,  OP_OBSERVE, REG_BOUNDARY_0, 32'h7FFF_FFFE, 1'b0, 32'd0, 64'h0},
      '{ROW_BEAT,  OP_OBSERVE, REG_BOUNDARY_0, 32'h0050_0000, 1'b0, 32'd0, 64'h0},
      '{ROW_BEAT,  OP_COLLECT, REG_BOUNDARY_0, 32'h0, 1'b1, 32'd8, 64'h0000_0000_804F_FFFE},
      // three buckets: samples above boundary 2 are dropped
      '{ROW_WRITE, OP_OBSERVE, REG_BUCKETS_IN_USE, 32'h0000_0003, 1'b0, 32'd0, 64'h0},
      '{ROW_BEAT,  OP_OBSERVE, REG_BOUNDARY_0, 32'h0001_0000, 1'b0, 32'd0, 64'h0},
      '{ROW_BEAT,  OP_OBSERVE, REG_BOUNDARY_0, 32'h7FFF_FFFF, 1'b0, 32'd0, 64'h0},
      '{ROW_BEAT,  OP_COLLECT, REG_BOUNDARY_0, 32'h0, 1'b1, 32'd3, 64'h0000_0000_804F_FFFE},
      // no bucket in use: everything dropped, collect returns nothing
      '{ROW_WRITE, OP_OBSERVE, REG_BUCKETS_IN_USE, 32'h0000_0000, 1'b0, 32'd0, 64'h0},
      '{ROW_BEAT,  OP_OBSERVE, REG_BOUNDARY_0, 32'h0000_0000, 1'b0, 32'd0, 64'h0},
      '{ROW_BEAT,  OP_COLLECT, REG_BOUNDARY_0, 32'h0, 1'b0, 32'd0, 64'h0},
      // writes to unmapped indexes are ignored
      '{ROW_WRITE, OP_OBSERVE, REG_SPARE_LO, 32'h1234_5678, 1'b0, 32'd0, 64'h0},
      '{ROW_WRITE, OP_OBSERVE, REG_SPARE_HI, 32'hFFFF_FFFF, 1'b0, 32'd0, 64'h0},
      // single bucket at the minimum boundary; stale counts survive
      '{ROW_WRITE, OP_OBSERVE, REG_BUCKETS_IN_USE, 32'h0000_0001, 1'b0, 32'd0, 64'h0},
      '{ROW_BEAT,  OP_OBSERVE, REG_BOUNDARY_0, 32'h8000_0000, 1'b0, 32'd0, 64'h0},
      '{ROW_BEAT,  OP_OBSERVE, REG_BOUNDARY_0, 32'h8000_0001, 1'b0, 32'd0, 64'h0},
      '{ROW_BEAT,  OP_COLLECT, REG_BOUNDARY_0, 32'h0, 1'b1, 32'd2, 64'h0000_0000_004F_FFFE},
      // unsorted boundaries: first match wins
      '{ROW_WRITE, OP_OBSERVE, REG_BOUNDARY_0,     32'h0064_0000, 1'b0, 32'd0, 64'h0},
      '{ROW_WRITE, OP_OBSERVE, REG_BUCKETS_IN_USE, 32'h0000_0007, 1'b0, 32'd0, 64'h0},
      '{ROW_BEAT,  OP_OBSERVE, REG_BOUNDARY_0, 32'hFFFB_0000, 1'b0, 32'd0, 64'h0},
      '{ROW_BEAT,  OP_OBSERVE, REG_BOUNDARY_0, 32'h0065_0000, 1'b0, 32'd0, 64'h0},
      '{ROW_BEAT,  OP_COLLECT, REG_BOUNDARY_0, 32'h0, 1'b0, 32'd0, 64'h0}
   };

   logic clock = 1'b0;
   logic reset;

   bhc_req_if req_bus ();
   bhc_rsp_if rsp_bus ();
   bhc_csr_if csr_bus ();

   bucket_histogram_counter i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // shadow of the block's registers and counters
   sample_type shadow_bounds [NUM_BOUND_REGS];
   use_type    shadow_in_use;
   count_type  shadow_counts [NUM_BOUND_REGS];
   sum_type    shadow_sum;

   bucket_report_type expected_reports [$];

   int mismatches  = 0;
   int cycle_count = 0;
   int sender_idle_pct = 0;
   int recv_stall_pct  = 0;
   bit stall_request   = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic note_mismatch(input string msg);
      mismatches++;
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
   endtask

   // register write as seen by the shadow copy
   function automatic void shadow_write(input logic [CSR_IDX_W-1:0] idx,
                                        input logic [CSR_DATA_W-1:0] data);
      if (idx < REG_BOUNDARY_0 + CSR_IDX_W'(NUM_BOUND_REGS)) begin
         shadow_bounds[idx - REG_BOUNDARY_0] = data[SAMPLE_W-1:0];
      end else if (idx == REG_BUCKETS_IN_USE) begin
         shadow_in_use = data[USE_W-1:0];
      end
   endfunction

   // bin one sample, or queue the cumulative snapshot a collect produces
   function automatic void bin_or_snapshot(input op_type op, input sample_type sample);
      int n;
      logic [COUNT_BITS:0] wide;
      count_type cum;
      bucket_report_type rpt;
      n = int'(shadow_in_use);
      if (n > BKT_SLOTS) n = BKT_SLOTS;
      if (op == OP_OBSERVE) begin
         for (int i = 0; i < n; i++) begin
            if ($signed(shadow_bounds[i]) >= $signed(sample)) begin
               if (shadow_counts[i] != {COUNT_BITS{1'b1}}) shadow_counts[i]++;
               shadow_sum += {{(SUM_W-SAMPLE_W){sample[SAMPLE_W-1]}}, sample};
               break;
            end
         end
      end else begin
         cum = '0;
         for (int i = 0; i < n; i++) begin
            wide = {1'b0, cum} + {1'b0, shadow_counts[i]};
            cum  = wide[COUNT_BITS] ? {COUNT_BITS{1'b1}} : wide[COUNT_BITS-1:0];
            rpt.bucket_number = OUT_NUM_W'(i);
            rpt.bucket_bound  = shadow_bounds[i];
            rpt.cum_count     = (64'(cum) > 64'hFFFF_FFFF) ? '1 : OUT_COUNT_W'(cum);
            rpt.sum_value     = shadow_sum;
            rpt.is_last       = (i + 1 == n);
            expected_reports = {expected_reports, rpt};
         end
      end
   endfunction

   // request beat; prediction happens at the accepting edge
   task automatic send_beat(input op_type op, input sample_type sample, input logic pinned,
                            input logic [OUT_COUNT_W-1:0] pin_total, input sum_type pin_sum);
      int last;
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid  <= 1'b1;
      req_bus.op     <= op;
      req_bus.sample <= sample;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      bin_or_snapshot(op, sample);
      last = expected_reports.size() - 1;
      if (pinned && op == OP_COLLECT && last >= 0) begin
         expected_reports[last].cum_count = pin_total;
         expected_reports[last].sum_value = pin_sum;
      end
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= data;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      shadow_write(idx, data);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   // block idle: all reports in, then room for a trailing observe to retire
   task automatic wait_idle();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (expected_reports.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   // samples clustered on and around the programmed boundaries
   function automatic sample_type pick_sample();
      sample_type b;
      int roll;
      b = shadow_bounds[$urandom_range(NUM_BOUND_REGS-1)];
      roll = $urandom_range(99);
      if (roll < 30) return b;
      if (roll < 50) return ($urandom_range(1)) ? b + 32'd1 : b - 32'd1;
      if (roll < 70) return b + sample_type'($urandom_range(32'h2_0000)) - 32'h1_0000;
      if (roll < 75) return ($urandom_range(1)) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      return sample_type'($urandom());
   endfunction

   task automatic load_setting(input int seg);
      int bq [NUM_BOUND_REGS];
      int n_use;
      for (int i = 0; i < NUM_BOUND_REGS; i++) begin
         if (seg % 2 == 0) bq[i] = int'($urandom());
         else bq[i] = int'($urandom_range(32'h20_0000)) - 32'h10_0000;
      end
      if (seg != 2) bq.sort();
      for (int i = 0; i < NUM_BOUND_REGS; i++) begin
         write_reg(REG_BOUNDARY_0 + CSR_IDX_W'(i), CSR_DATA_W'(bq[i]));
      end
      case (seg)
         0, 4:    n_use = 7;
         1:       n_use = 1;
         3:       n_use = 0;
         default: n_use = $urandom_range(7);
      endcase
      // junk in the upper data bits must not matter
      write_reg(REG_BUCKETS_IN_USE, {29'($urandom_range(32'h1FFF_FFFF)), 3'(n_use)});
   endtask

   // receiver: random stalls, plus one long hold-off on request
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_request) begin
            stall_left    = STALL_HOLD;
            stall_request = 1'b0;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // result checker
   always @(posedge clock) begin
      bucket_report_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (expected_reports.size() == 0) begin
            note_mismatch($sformatf("unexpected result beat for bucket %0d",
                                    rsp_bus.bucket_number));
         end else begin
            want = expected_reports.pop_front();
            if (rsp_bus.bucket_number !== want.bucket_number)
               note_mismatch($sformatf("bucket_number %0d, want %0d",
                                       rsp_bus.bucket_number, want.bucket_number));
            if (rsp_bus.bucket_bound !== want.bucket_bound)
               note_mismatch($sformatf("bucket %0d bucket_bound %h, want %h", want.bucket_number,
                                       rsp_bus.bucket_bound, want.bucket_bound));
            if (rsp_bus.cum_count !== want.cum_count)
               note_mismatch($sformatf("bucket %0d cum_count %0d, want %0d",
                                       want.bucket_number, rsp_bus.cum_count,
                                       want.cum_count));
            if (rsp_bus.sum_value !== want.sum_value)
               note_mismatch($sformatf("bucket %0d sum_value %h, want %h", want.bucket_number,
                                       rsp_bus.sum_value, want.sum_value));
            if (rsp_bus.is_last !== want.is_last)
               note_mismatch($sformatf("bucket %0d is_last %b, want %b", want.bucket_number,
                                       rsp_bus.is_last, want.is_last));
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      int drain;
      reset          = 1'b1;
      req_bus.valid  = 1'b0;
      req_bus.op     = OP_OBSERVE;
      req_bus.sample = '0;
      csr_bus.valid  = 1'b0;
      csr_bus.index  = REG_BOUNDARY_0;
      csr_bus.data   = '0;
      for (int i = 0; i < NUM_BOUND_REGS; i++) begin
         shadow_bounds[i] = '0;
         shadow_counts[i] = '0;
      end
      shadow_in_use = USE_RESET;
      shadow_sum    = '0;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed part, back to back
      foreach (script[r]) begin
         if (script[r].kind == ROW_WRITE) begin
            wait_idle();
            write_reg(script[r].index, script[r].value);
         end else begin
            send_beat(script[r].op, script[r].value, script[r].pinned,
                      script[r].pin_total, script[r].pin_sum);
         end
      end

      // random part: a new setting and a new idling pattern per segment
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         wait_idle();
         load_setting(seg);
         case (seg % 4)
            0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin sender_idle_pct = 85; recv_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  recv_stall_pct = 85; end
            default: begin sender_idle_pct = 9; recv_stall_pct = 9; end
         endcase
         // long receiver hold-off while collects keep coming
         if (seg == 4) stall_request = 1'b1;
         for (int k = 0; k < SEG_ITEMS; k++) begin
            if ((seg == 4 && k < 4) || k == SEG_ITEMS - 1 || $urandom_range(99) < 12)
               send_beat(OP_COLLECT, sample_type'($urandom()), 1'b0, '0, '0);
            else
               send_beat(OP_OBSERVE, pick_sample(), 1'b0, '0, '0);
         end
      end

      // drain
      @(negedge clock);
      req_bus.valid <= 1'b0;
      drain = 0;
      while (expected_reports.size() != 0 && drain < 20_000) begin
         @(negedge clock);
         drain++;
      end
      repeat (16) @(negedge clock);
      while (expected_reports.size() != 0) begin
         note_mismatch($sformatf("result for bucket %0d never arrived",
                                 expected_reports[0].bucket_number));
         void'(expected_reports.pop_front());
      end

      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
